### rtl/vfs_pkg.sv
`default_nettype none
package vfs_pkg;

    localparam int INDEX_COUNT_DEF = 128;
    localparam int TYPE_COUNT      = 4;
    localparam int WIDTH_CLASSES   = 4;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_VMCS     = 2'd1,
        ST_UNSUPPORTED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        WC_16  = 2'd0,
        WC_64  = 2'd1,
        WC_32  = 2'd2,
        WC_NAT = 2'd3
    } t_wclass;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Classified access as it travels from the front to the back.
    typedef struct packed {
        t_status status;
        logic    is_write;
        logic    high;
        t_wclass width;
    } t_op;

    localparam int OP_W = $bits(t_op);

endpackage
`default_nettype wire

### rtl/vmcs_field_store_unit.sv
// VMCS field store: VMREAD/VMWRITE accesses addressed by 32-bit field encodings.
// Input channel: i_in_valid / o_in_stall with i_mode, i_encoding and
// i_write_value; a transfer happens on a rising edge with valid high and stall
// low. Output channel: o_out_valid / i_out_stall with o_status, o_read_data and
// o_write_count, one result per access, in order.
// i_cfg_we / i_cfg_data write the current-VMCS flag; write it only while idle.
// One access per cycle is sustained while the output is not stalled: the front
// classifies into a 2-entry queue, and the back pops one access a cycle into
// its single read/write port per half-slot memory, then a result stage and an
// output register.
// After reset the back clears the 16 * INDEX_COUNT slots one per cycle
// (2048 slots at the default); o_in_stall stays high throughout, while
// configuration writes are still taken. A stalled output holds its result;
// the result stage and the queue absorb up to three more accesses before
// o_in_stall rises.
`default_nettype none
module vmcs_field_store_unit import vfs_pkg::*; #(
    parameter int INDEX_COUNT = INDEX_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_encoding,
    input  wire logic [63:0] i_write_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_read_data,
    output logic [31:0]      o_write_count
);

    localparam int SLOT_AW = $clog2(WIDTH_CLASSES * TYPE_COUNT * INDEX_COUNT);
    localparam int QW      = SLOT_AW + 64 + OP_W;

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic               back_busy;
    t_op                f_op;
    logic [SLOT_AW-1:0] f_slot;
    logic [63:0]        f_value;
    logic [QW-1:0]      q_wdata;
    logic [QW-1:0]      q_rdata;
    t_op                h_op;
    logic [SLOT_AW-1:0] h_slot;
    logic [63:0]        h_value;

    vfs_front #(
        .INDEX_COUNT (INDEX_COUNT),
        .SLOT_AW     (SLOT_AW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_encoding    (i_encoding),
        .i_write_value (i_write_value),
        .i_q_full      (q_full),
        .i_back_busy   (back_busy),
        .o_push        (push),
        .o_op          (f_op),
        .o_slot        (f_slot),
        .o_value       (f_value)
    );

    assign q_wdata = {f_slot, f_value, f_op};

    vfs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    assign h_op    = t_op'(q_rdata[OP_W-1:0]);
    assign h_value = q_rdata[OP_W+63:OP_W];
    assign h_slot  = q_rdata[QW-1:OP_W+64];

    vfs_back #(
        .INDEX_COUNT (INDEX_COUNT),
        .SLOT_AW     (SLOT_AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (!q_empty),
        .i_op          (h_op),
        .i_slot        (h_slot),
        .i_value       (h_value),
        .o_pop         (pop),
        .o_busy        (back_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_write_count (o_write_count)
    );

endmodule
`default_nettype wire

### rtl/vfs_front.sv
`default_nettype none
module vfs_front import vfs_pkg::*; #(
    parameter int INDEX_COUNT = INDEX_COUNT_DEF,
    parameter int SLOT_AW     = $clog2(WIDTH_CLASSES * TYPE_COUNT * INDEX_COUNT)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_mode,
    input  wire logic [31:0]        i_encoding,
    input  wire logic [63:0]        i_write_value,
    input  wire logic               i_q_full,
    input  wire logic               i_back_busy,
    output logic                    o_push,
    output t_op                     o_op,
    output logic [SLOT_AW-1:0]      o_slot,
    output logic [63:0]             o_value
);

    logic          r_vmcs_active;
    logic [8:0]    idx;
    logic [1:0]    typ;
    t_wclass       wid;
    logic          hi;
    logic          bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmcs_active <= 1'b0;
        end else if (i_cfg_we) begin
            r_vmcs_active <= i_cfg_data;
        end
    end

    assign idx = i_encoding[9:1];
    assign typ = i_encoding[11:10];
    assign wid = t_wclass'(i_encoding[14:13]);
    assign hi  = i_encoding[0];

    // Bit 12 is not decoded, so encodings differing only there share a slot.
    assign bad = (|i_encoding[31:15])
               || ({1'b0, idx} >= 10'(INDEX_COUNT))
               || (hi && (wid != WC_64));

    always_comb begin
        o_op.is_write = (i_mode == MODE_WRITE);
        o_op.high     = hi;
        o_op.width    = wid;
        if (!r_vmcs_active) begin
            o_op.status = ST_NO_VMCS;
        end else if (bad) begin
            o_op.status = ST_UNSUPPORTED;
        end else begin
            o_op.status = ST_OK;
        end
    end

    assign o_slot = SLOT_AW'(wid) * SLOT_AW'(TYPE_COUNT * INDEX_COUNT)
                  + SLOT_AW'(typ) * SLOT_AW'(INDEX_COUNT)
                  + SLOT_AW'(idx);

    assign o_value    = i_write_value;
    assign o_in_stall = i_q_full || i_back_busy;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule
`default_nettype wire

### rtl/vfs_queue.sv
`default_nettype none
module vfs_queue import vfs_pkg::*; #(
    parameter int WIDTH = OP_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_rdata
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/vfs_back.sv
`default_nettype none
module vfs_back import vfs_pkg::*; #(
    parameter int INDEX_COUNT = INDEX_COUNT_DEF,
    parameter int SLOT_AW     = $clog2(WIDTH_CLASSES * TYPE_COUNT * INDEX_COUNT)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_head_valid,
    input  wire t_op                i_op,
    input  wire logic [SLOT_AW-1:0] i_slot,
    input  wire logic [63:0]        i_value,
    output logic                    o_pop,
    output logic                    o_busy,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_status,
    output logic [63:0]             o_read_data,
    output logic [31:0]             o_write_count
);

    localparam int DEPTH = WIDTH_CLASSES * TYPE_COUNT * INDEX_COUNT;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'b01,
        BK_RUN   = 2'b10
    } t_back_state;

    t_back_state        r_state;
    logic [SLOT_AW-1:0] r_clr_addr;

    // Each slot is kept as two 32-bit halves so a high-half write needs no read.
    logic [31:0]        r_mem_lo [DEPTH];
    logic [31:0]        r_mem_hi [DEPTH];
    logic [31:0]        r_rd_lo;
    logic [31:0]        r_rd_hi;

    logic [31:0]        r_serial;
    logic               r_s1_valid;
    t_op                r_s1_op;
    logic [31:0]        r_s1_count;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [63:0]        r_out_data;
    logic [31:0]        r_out_count;

    logic               clearing;
    logic               s1_move;
    logic               do_write;
    logic               we_lo;
    logic               we_hi;
    logic [SLOT_AW-1:0] mem_addr;
    logic [31:0]        wdata_lo;
    logic [31:0]        wdata_hi;
    logic [63:0]        result;

    assign clearing = (r_state == BK_CLEAR);
    assign s1_move  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_pop    = i_head_valid && !clearing && (!r_s1_valid || s1_move);
    assign do_write = o_pop && i_op.is_write && (i_op.status == ST_OK);

    always_comb begin
        mem_addr = i_slot;
        we_lo    = do_write && !i_op.high;
        we_hi    = do_write;
        wdata_lo = (i_op.width == WC_16) ? {16'd0, i_value[15:0]} : i_value[31:0];
        if (i_op.high) begin
            wdata_hi = i_value[31:0];
        end else if (i_op.width == WC_64 || i_op.width == WC_NAT) begin
            wdata_hi = i_value[63:32];
        end else begin
            wdata_hi = 32'd0;
        end
        if (clearing) begin
            mem_addr = r_clr_addr;
            we_lo    = 1'b1;
            we_hi    = 1'b1;
            wdata_lo = 32'd0;
            wdata_hi = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_lo) begin
            r_mem_lo[mem_addr] <= wdata_lo;
        end
        if (o_pop) begin
            r_rd_lo <= r_mem_lo[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_hi) begin
            r_mem_hi[mem_addr] <= wdata_hi;
        end
        if (o_pop) begin
            r_rd_hi <= r_mem_hi[i_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
        end else begin
            case (r_state)
                BK_CLEAR: begin
                    r_clr_addr <= r_clr_addr + SLOT_AW'(1);
                    if (r_clr_addr == SLOT_AW'(DEPTH - 1)) begin
                        r_state <= BK_RUN;
                    end
                end
                BK_RUN: begin
                    r_clr_addr <= '0;
                end
                default: begin
                    r_state <= BK_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial   <= 32'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (do_write) begin
                r_serial <= r_serial + 32'd1;
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_op    <= i_op;
            r_s1_count <= r_serial + {31'd0, do_write};
        end
    end

    always_comb begin
        if (r_s1_op.status != ST_OK || r_s1_op.is_write) begin
            result = 64'd0;
        end else if (r_s1_op.high) begin
            result = {32'd0, r_rd_hi};
        end else begin
            case (r_s1_op.width)
                WC_16:   result = {48'd0, r_rd_lo[15:0]};
                WC_32:   result = {32'd0, r_rd_lo};
                default: result = {r_rd_hi, r_rd_lo};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= r_s1_op.status;
            r_out_data   <= result;
            r_out_count  <= r_s1_count;
        end
    end

    assign o_busy        = clearing;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_data   = r_out_data;
    assign o_write_count = r_out_count;

    a_no_pop_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_pop)
        else $error("access taken from the queue during the clearing pass");

    a_serial_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> (r_serial == $past(r_serial) + 32'd1))
        else $error("write counter did not advance by one on a write");

    a_fail_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_data == 64'd0))
        else $error("failed access returned nonzero data");

endmodule
`default_nettype wire

### bench/vmcs_field_store_unit_tb.sv
`timescale 1ns / 1ps

// Mirror of the field store: it keeps its own copy of every slot, the write
// counter and the current-VMCS flag, and queues the result owed for each
// accepted access.
class vmcs_field_shadow;
    localparam int INDEX_COUNT = vfs_pkg::INDEX_COUNT_DEF;
    localparam int TYPE_COUNT  = vfs_pkg::TYPE_COUNT;
    localparam int SLOT_TOTAL  = vfs_pkg::WIDTH_CLASSES * TYPE_COUNT * INDEX_COUNT;

    typedef struct {
        vfs_pkg::t_status status;
        bit [63:0]        read_data;
        bit [31:0]        write_count;
    } field_result_t;

    bit [63:0]     slot_value [SLOT_TOTAL];
    bit [31:0]     write_serial;
    bit            vmcs_active;
    field_result_t owed_results [$];
    int            mismatch_count;

    function new();
        foreach (slot_value[i]) slot_value[i] = '0;
        write_serial   = '0;
        vmcs_active    = 1'b0;
        mismatch_count = 0;
    endfunction

    function bit [63:0] narrow(bit [63:0] value, vfs_pkg::t_wclass wid);
        case (wid)
            vfs_pkg::WC_16: return {48'd0, value[15:0]};
            vfs_pkg::WC_32: return {32'd0, value[31:0]};
            default:        return value;
        endcase
    endfunction

    function void note_access(bit mode, bit [31:0] enc, bit [63:0] value);
        field_result_t    res;
        bit [8:0]         idx;
        bit [1:0]         typ;
        vfs_pkg::t_wclass wid;
        bit               high;
        int               slot;
        idx  = enc[9:1];
        typ  = enc[11:10];
        wid  = vfs_pkg::t_wclass'(enc[14:13]);
        high = enc[0];
        res.status    = vfs_pkg::ST_OK;
        res.read_data = '0;
        // The current-VMCS check wins over any problem with the encoding.
        if (!vmcs_active) begin
            res.status = vfs_pkg::ST_NO_VMCS;
        end else if (enc[31:15] != '0 || int'(idx) >= INDEX_COUNT
                     || (high && wid != vfs_pkg::WC_64)) begin
            res.status = vfs_pkg::ST_UNSUPPORTED;
        end else begin
            slot = (int'(wid) * TYPE_COUNT + int'(typ)) * INDEX_COUNT + int'(idx);
            if (mode == vfs_pkg::MODE_WRITE) begin
                if (high) slot_value[slot][63:32] = value[31:0];
                else slot_value[slot] = narrow(value, wid);
                write_serial = write_serial + 32'd1;
            end else if (high) begin
                res.read_data = {32'd0, slot_value[slot][63:32]};
            end else begin
                res.read_data = narrow(slot_value[slot], wid);
            end
        end
        res.write_count = write_serial;
        owed_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [63:0] read_data,
                               logic [31:0] write_count);
        field_result_t res;
        if (owed_results.size() == 0) begin
            $error("result with none owed: status %0d read_data %h write_count %h",
                   status, read_data, write_count);
            mismatch_count++;
            return;
        end
        res = owed_results.pop_front();
        if (status !== res.status) begin
            $error("field status: expected %0d, actual %0d", res.status, status);
            mismatch_count++;
        end
        if (read_data !== res.read_data) begin
            $error("field read_data: expected %h, actual %h", res.read_data, read_data);
            mismatch_count++;
        end
        if (write_count !== res.write_count) begin
            $error("field write_count: expected %h, actual %h",
                   res.write_count, write_count);
            mismatch_count++;
        end
    endfunction
endclass

module vmcs_field_store_unit_tb;
    import vfs_pkg::*;

    // Clearing pass, every result stalled as long as the stall pattern allows,
    // and every sender gap, with plenty of headroom.
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = MODE_READ;
    logic [31:0] i_encoding = '0;
    logic [63:0] i_write_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_read_data;
    logic [31:0] o_write_count;

    vmcs_field_shadow shadow = new();
    int cycle_count = 0;
    int stall_style = 0;
    int stall_run = 0;

    vmcs_field_store_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_encoding    (i_encoding),
        .i_write_value (i_write_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_write_count (o_write_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            shadow.check_result(o_status, o_read_data, o_write_count);
    end

    // The receiver varies its style of back-pressure, picked at random from four styles.
    always @(negedge i_clk) begin
        if (cycle_count % 256 == 0) stall_style = $urandom_range(3);
        case (stall_style)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(99) < 30);
            2: begin
                if (stall_run == 0) begin
                    i_out_stall = !i_out_stall;
                    stall_run   = $urandom_range(1, 12);
                end else begin
                    stall_run--;
                end
            end
            default: i_out_stall = (cycle_count % 3 == 0);
        endcase
    end

    function automatic bit [31:0] field_enc(t_wclass wid, bit [1:0] typ, bit [8:0] idx,
                                            bit high);
        return {17'd0, wid, 1'b0, typ, idx, high};
    endfunction

    task automatic send_access(bit mode, bit [31:0] enc, bit [63:0] value);
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_mode        = mode;
        i_encoding    = enc;
        i_write_value = value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        shadow.note_access(mode, enc, value);
    endtask

    task automatic hold_input(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic set_vmcs_active(bit active);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = active;
        shadow.vmcs_active = active;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (shadow.owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed accesses, half of them crowded onto a few indexes so
    // that reads find written data; the rest are rejected encodings.
    task automatic random_access();
        int        pick;
        t_wclass   wid;
        bit [1:0]  typ;
        bit [8:0]  idx;
        bit        high;
        bit [31:0] enc;
        bit [63:0] value;
        pick = $urandom_range(99);
        wid  = t_wclass'($urandom_range(3));
        typ  = 2'($urandom_range(3));
        idx  = $urandom_range(1) ? 9'($urandom_range(7)) : 9'($urandom_range(127));
        high = (wid == WC_64) && $urandom_range(1);
        if (pick < 8) begin
            idx = 9'($urandom_range(511, 128));
        end else if (pick < 14) begin
            wid = t_wclass'($urandom_range(2));
            if (wid == WC_64) wid = WC_NAT;
            high = 1'b1;
        end
        enc = field_enc(wid, typ, idx, high);
        if ($urandom_range(1)) enc[12] = 1'b1;
        if (pick >= 14 && pick < 18) enc = $urandom();
        else if (pick >= 18 && pick < 22) enc[$urandom_range(31, 15)] = 1'b1;
        case ($urandom_range(9))
            0:       value = '0;
            1:       value = '1;
            default: value = {$urandom(), $urandom()};
        endcase
        send_access($urandom_range(1) ? MODE_WRITE : MODE_READ, enc, value);
    endtask

    task automatic random_run(int count);
        int burst_left;
        burst_left = 0;
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(3) != 0) hold_input($urandom_range(1, 8));
            end
            burst_left--;
            random_access();
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // No current VMCS: every access is refused and nothing is stored.
        set_vmcs_active(1'b0);
        send_access(MODE_READ, field_enc(WC_16, 2'd0, 9'd0, 1'b0), '0);
        send_access(MODE_WRITE, field_enc(WC_32, 2'd2, 9'd3, 1'b0), '1);
        send_access(MODE_WRITE, 32'hFFFF_FFFF, '1);
        drain_results();

        set_vmcs_active(1'b1);
        send_access(MODE_READ, field_enc(WC_32, 2'd2, 9'd3, 1'b0), '0);
        send_access(MODE_READ, field_enc(WC_16, 2'd0, 9'd0, 1'b0), '0);
        send_access(MODE_WRITE, field_enc(WC_16, 2'd0, 9'd0, 1'b0), '1);
        send_access(MODE_READ, field_enc(WC_16, 2'd0, 9'd0, 1'b0), '0);
        send_access(MODE_WRITE, field_enc(WC_64, 2'd1, 9'd5, 1'b0), 64'h0123_4567_89AB_CDEF);
        send_access(MODE_WRITE, field_enc(WC_64, 2'd1, 9'd5, 1'b1), 64'hA5A5_A5A5_DEAD_BEEF);
        send_access(MODE_READ, field_enc(WC_64, 2'd1, 9'd5, 1'b0), '0);
        send_access(MODE_READ, field_enc(WC_64, 2'd1, 9'd5, 1'b1), '0);
        send_access(MODE_WRITE, field_enc(WC_32, 2'd3, 9'd127, 1'b0), '1);
        send_access(MODE_READ, field_enc(WC_32, 2'd3, 9'd127, 1'b0), '0);
        send_access(MODE_WRITE, field_enc(WC_NAT, 2'd2, 9'd64, 1'b0), '1);
        send_access(MODE_READ, field_enc(WC_NAT, 2'd2, 9'd64, 1'b0), '0);
        // Bit 12 is not decoded, so both encodings name the same slot.
        send_access(MODE_WRITE, field_enc(WC_16, 2'd0, 9'd1, 1'b0) | 32'h0000_1000,
                    64'h0000_0000_0000_1234);
        send_access(MODE_READ, field_enc(WC_16, 2'd0, 9'd1, 1'b0), '0);
        send_access(MODE_READ, field_enc(WC_32, 2'd0, 9'd128, 1'b0), '0);
        send_access(MODE_WRITE, field_enc(WC_NAT, 2'd3, 9'd511, 1'b0), '1);
        send_access(MODE_WRITE, 32'h0000_8000, '1);
        send_access(MODE_READ, 32'hFFFF_FFFF, '0);
        send_access(MODE_WRITE, field_enc(WC_16, 2'd0, 9'd0, 1'b1), '1);
        send_access(MODE_READ, field_enc(WC_32, 2'd1, 9'd2, 1'b1), '0);
        send_access(MODE_WRITE, field_enc(WC_NAT, 2'd2, 9'd4, 1'b1), '1);
        send_access(MODE_WRITE, field_enc(WC_16, 2'd0, 9'd0, 1'b0), '0);
        send_access(MODE_READ, field_enc(WC_16, 2'd0, 9'd0, 1'b0), '0);
        drain_results();

        random_run(1100);
        drain_results();
        set_vmcs_active(1'b0);
        random_run(150);
        drain_results();
        set_vmcs_active(1'b1);
        random_run(200);
        drain_results();

        if (shadow.mismatch_count == 0 && shadow.owed_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
